### rtl/power_supply_interlock_supervisor_macros.svh
// assertion macros for the interlock supervisor
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef POWER_SUPPLY_INTERLOCK_SUPERVISOR_MACROS_SVH
`define POWER_SUPPLY_INTERLOCK_SUPERVISOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PSIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/psis_pkg.sv
// shared types and constants for the interlock supervisor
// no dependencies
package psis_pkg;

  localparam int unsigned LIMIT_W = 23;
  localparam int unsigned HARD_W  = 5;
  localparam int unsigned SOFT_W  = 7;
  localparam int unsigned REQ_W   = 7;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // hard mask bit positions
  localparam int unsigned H_OVERCURRENT = 0;
  localparam int unsigned H_BANK_OVER   = 2;
  localparam int unsigned H_BANK_UNDER  = 3;

  // soft mask bit positions
  localparam int unsigned S_SENSOR_A   = 2;
  localparam int unsigned S_SENSOR_B   = 3;
  localparam int unsigned S_DIFFERENCE = 4;
  localparam int unsigned S_FEEDBACK_A = 5;
  localparam int unsigned S_FEEDBACK_B = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK    = 3'd0,
    CMD_TURN_ON  = 3'd1,
    CMD_TURN_OFF = 3'd2,
    CMD_RESET    = 3'd3,
    CMD_EXT_HARD = 3'd4,
    CMD_EXT_SOFT = 3'd5
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF  = 2'd0,
    MODE_ITLK = 2'd1,
    MODE_ON   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LOAD_CURRENT   = 3'd0,
    CFG_MAX_SENSOR_DIFF    = 3'd1,
    CFG_MAX_BANK_VOLTAGE   = 3'd2,
    CFG_MIN_BANK_VOLTAGE   = 3'd3,
    CFG_MAX_IDLE_CURRENT   = 3'd4,
    CFG_MIN_ACTIVE_CURRENT = 3'd5
  } cfg_idx_e;

  localparam logic [LIMIT_W-1:0] LIMIT_FULL = {LIMIT_W{1'b1}};

  typedef struct packed {
    logic [LIMIT_W-1:0] max_load_current;
    logic [LIMIT_W-1:0] max_sensor_difference;
    logic [LIMIT_W-1:0] max_bank_voltage;
    logic [LIMIT_W-1:0] min_bank_voltage;
    logic [LIMIT_W-1:0] max_idle_sensor_current;
    logic [LIMIT_W-1:0] min_active_sensor_current;
  } limits_t;

  // comparator results for one sample set
  typedef struct packed {
    logic [HARD_W-1:0] hard_trip;
    logic [SOFT_W-1:0] soft_trip;
    logic              bank_low;
  } check_flags_t;

  typedef struct packed {
    mode_e             mode;
    logic [HARD_W-1:0] hard_mask;
    logic [SOFT_W-1:0] soft_mask;
    logic              drive_on;
    logic              loop_open;
    logic              cleared;
  } status_t;

endpackage

### rtl/psis_limit_check.sv
// limit comparators: mean and difference current, bank voltage, sensor feedback
// depends on psis_pkg
module psis_limit_check import psis_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  limits_t                  limits_i,
  input  logic signed [SAMPLE_WIDTH-1:0] current_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0] current_b_i,
  input  logic signed [SAMPLE_WIDTH-1:0] bank_voltage_i,
  input  logic                     sensor_a_ok_i,
  input  logic                     sensor_a_active_i,
  input  logic                     sensor_b_ok_i,
  input  logic                     sensor_b_active_i,
  output check_flags_t             flags_o
);

  // room for the sum of two samples, its negation and a doubled limit
  localparam int unsigned EW = ((SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W) + 3;

  logic signed [EW-1:0] a_x, b_x, v_x, sum_x, diff_x;
  logic signed [EW-1:0] sum_mag, diff_mag, a_mag, b_mag;
  logic signed [EW-1:0] max_load2, max_diff, max_bank, min_bank, max_idle, min_active;
  logic                 fb_a_bad, fb_b_bad;

  assign a_x = EW'(current_a_i);
  assign b_x = EW'(current_b_i);
  assign v_x = EW'(bank_voltage_i);

  assign sum_x  = a_x + b_x;
  assign diff_x = a_x - b_x;

  assign sum_mag  = sum_x[EW-1]  ? -sum_x  : sum_x;
  assign diff_mag = diff_x[EW-1] ? -diff_x : diff_x;
  assign a_mag    = a_x[EW-1]    ? -a_x    : a_x;
  assign b_mag    = b_x[EW-1]    ? -b_x    : b_x;

  // mean above limit tested as sum above twice the limit
  assign max_load2  = $signed({{(EW-LIMIT_W-1){1'b0}}, limits_i.max_load_current, 1'b0});
  assign max_diff   = $signed({{(EW-LIMIT_W){1'b0}}, limits_i.max_sensor_difference});
  assign max_bank   = $signed({{(EW-LIMIT_W){1'b0}}, limits_i.max_bank_voltage});
  assign min_bank   = $signed({{(EW-LIMIT_W){1'b0}}, limits_i.min_bank_voltage});
  assign max_idle   = $signed({{(EW-LIMIT_W){1'b0}}, limits_i.max_idle_sensor_current});
  assign min_active = $signed({{(EW-LIMIT_W){1'b0}}, limits_i.min_active_sensor_current});

  assign fb_a_bad = sensor_a_active_i ? (a_mag < min_active) : (a_mag > max_idle);
  assign fb_b_bad = sensor_b_active_i ? (b_mag < min_active) : (b_mag > max_idle);

  always_comb begin
    flags_o = '0;
    flags_o.hard_trip[H_OVERCURRENT] = sum_mag > max_load2;
    flags_o.hard_trip[H_BANK_OVER]   = v_x > max_bank;
    flags_o.soft_trip[S_DIFFERENCE]  = diff_mag > max_diff;
    flags_o.soft_trip[S_SENSOR_A]    = !sensor_a_ok_i;
    flags_o.soft_trip[S_SENSOR_B]    = !sensor_b_ok_i;
    flags_o.soft_trip[S_FEEDBACK_A]  = fb_a_bad;
    flags_o.soft_trip[S_FEEDBACK_B]  = fb_b_bad;
    flags_o.bank_low                 = v_x < min_bank;
  end

endmodule

### rtl/psis_state.sv
// supply mode and latched interlock masks, updated once per command beat
// depends on psis_pkg
module psis_state import psis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cmd_e               command_i,
  input  logic [REQ_W-1:0]   request_bits_i,
  input  check_flags_t       flags_i,
  output status_t            status_o
);

  mode_e             mode_q, mode_d;
  logic [HARD_W-1:0] hard_q, hard_d, hard_req;
  logic [SOFT_W-1:0] soft_q, soft_d, soft_req;
  logic              drive_q, drive_d;
  logic              loop_q, loop_d;
  logic              cleared_q, cleared_d;

  assign hard_req = request_bits_i[HARD_W-1:0];
  assign soft_req = request_bits_i[SOFT_W-1:0];

  always_comb begin
    mode_d    = mode_q;
    hard_d    = hard_q;
    soft_d    = soft_q;
    drive_d   = drive_q;
    loop_d    = loop_q;
    cleared_d = 1'b0;
    unique case (command_i)
      CMD_CHECK: begin
        if (|(flags_i.hard_trip & ~hard_q) || |(flags_i.soft_trip & ~soft_q)) begin
          drive_d   = 1'b0;
          cleared_d = 1'b1;
          mode_d    = MODE_ITLK;
        end
        hard_d = hard_q | flags_i.hard_trip;
        soft_d = soft_q | flags_i.soft_trip;
        // undervoltage only counts while still running after the other checks
        if (mode_d == MODE_ON && flags_i.bank_low && !hard_d[H_BANK_UNDER]) begin
          drive_d              = 1'b0;
          cleared_d            = 1'b1;
          mode_d               = MODE_ITLK;
          hard_d[H_BANK_UNDER] = 1'b1;
        end
      end
      CMD_TURN_ON: begin
        if (mode_q == MODE_OFF) begin
          if (flags_i.bank_low) begin
            if (!hard_q[H_BANK_UNDER]) begin
              drive_d              = 1'b0;
              cleared_d            = 1'b1;
              mode_d               = MODE_ITLK;
              hard_d[H_BANK_UNDER] = 1'b1;
            end
          end else begin
            cleared_d = 1'b1;
            loop_d    = 1'b1;
            mode_d    = MODE_ON;
            drive_d   = 1'b1;
          end
        end
      end
      CMD_TURN_OFF: begin
        drive_d   = 1'b0;
        cleared_d = 1'b1;
        if (mode_q != MODE_ITLK) begin
          mode_d = MODE_OFF;
        end
      end
      CMD_RESET: begin
        hard_d = '0;
        soft_d = '0;
        if (mode_q != MODE_ON) begin
          mode_d = MODE_OFF;
        end
      end
      CMD_EXT_HARD: begin
        // overlapping or empty requests are dropped as a whole
        if (|hard_req && !(|(hard_q & hard_req))) begin
          drive_d   = 1'b0;
          cleared_d = 1'b1;
          mode_d    = MODE_ITLK;
          hard_d    = hard_q | hard_req;
        end
      end
      CMD_EXT_SOFT: begin
        if (|soft_req && !(|(soft_q & soft_req))) begin
          drive_d   = 1'b0;
          cleared_d = 1'b1;
          mode_d    = MODE_ITLK;
          soft_d    = soft_q | soft_req;
        end
      end
      default: begin
        cleared_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      hard_q    <= '0;
      soft_q    <= '0;
      drive_q   <= 1'b0;
      loop_q    <= 1'b0;
      cleared_q <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      hard_q    <= hard_d;
      soft_q    <= soft_d;
      drive_q   <= drive_d;
      loop_q    <= loop_d;
      cleared_q <= cleared_d;
    end
  end

  assign status_o.mode      = mode_q;
  assign status_o.hard_mask = hard_q;
  assign status_o.soft_mask = soft_q;
  assign status_o.drive_on  = drive_q;
  assign status_o.loop_open = loop_q;
  assign status_o.cleared   = cleared_q;

endmodule

### rtl/power_supply_interlock_supervisor.sv
// Interlock supervisor for a DC/DC converter stage. Every command beat yields
// exactly one status beat showing mode, latched masks and drive state after
// that command. Items flow through an input register and then the state
// registers, which double as the status register. One item is taken every
// cycle while no output beat is held; the only stall is a held output beat,
// which lets one more beat into the input register and then holds off the
// input. The limit registers are to be written by the user through the cfg
// port while the block idles; the block itself does not enforce this.
// Depends on psis_pkg, psis_limit_check, psis_state and the assertion macros.
`include "power_supply_interlock_supervisor_macros.svh"

module power_supply_interlock_supervisor import psis_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [LIMIT_W-1:0]             cfg_data_i,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [CMD_W-1:0]               command_i,
  input  logic signed [SAMPLE_WIDTH-1:0] load_current_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0] load_current_b_i,
  input  logic signed [SAMPLE_WIDTH-1:0] bank_voltage_i,
  input  logic                           sensor_a_ok_i,
  input  logic                           sensor_a_active_i,
  input  logic                           sensor_b_ok_i,
  input  logic                           sensor_b_active_i,
  input  logic [REQ_W-1:0]               request_bits_i,
  // status channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [MODE_W-1:0]              supply_mode_o,
  output logic [HARD_W-1:0]              hard_interlocks_o,
  output logic [SOFT_W-1:0]              soft_interlocks_o,
  output logic                           drive_enable_o,
  output logic                           loop_open_o,
  output logic                           controller_cleared_o
);

  limits_t                        limits_q;
  logic                           s1_valid_q, out_valid_q;
  logic                           accept, advance;
  cmd_e                           cmd_q;
  logic signed [SAMPLE_WIDTH-1:0] ia_q, ib_q, vb_q;
  logic                           a_ok_q, a_act_q, b_ok_q, b_act_q;
  logic [REQ_W-1:0]               req_q;
  check_flags_t                   flags;
  status_t                        status;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.max_load_current          <= LIMIT_FULL;
      limits_q.max_sensor_difference     <= LIMIT_FULL;
      limits_q.max_bank_voltage          <= LIMIT_FULL;
      limits_q.min_bank_voltage          <= '0;
      limits_q.max_idle_sensor_current   <= LIMIT_FULL;
      limits_q.min_active_sensor_current <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_LOAD_CURRENT:   limits_q.max_load_current          <= cfg_data_i;
        CFG_MAX_SENSOR_DIFF:    limits_q.max_sensor_difference     <= cfg_data_i;
        CFG_MAX_BANK_VOLTAGE:   limits_q.max_bank_voltage          <= cfg_data_i;
        CFG_MIN_BANK_VOLTAGE:   limits_q.min_bank_voltage          <= cfg_data_i;
        CFG_MAX_IDLE_CURRENT:   limits_q.max_idle_sensor_current   <= cfg_data_i;
        CFG_MIN_ACTIVE_CURRENT: limits_q.min_active_sensor_current <= cfg_data_i;
        default: limits_q <= limits_q;
      endcase
    end
  end

  // stage 1 moves on when the status register is free or being emptied
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept || (s1_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      ia_q    <= load_current_a_i;
      ib_q    <= load_current_b_i;
      vb_q    <= bank_voltage_i;
      a_ok_q  <= sensor_a_ok_i;
      a_act_q <= sensor_a_active_i;
      b_ok_q  <= sensor_b_ok_i;
      b_act_q <= sensor_b_active_i;
      req_q   <= request_bits_i;
    end
  end

  psis_limit_check #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_check (
    .limits_i          (limits_q),
    .current_a_i       (ia_q),
    .current_b_i       (ib_q),
    .bank_voltage_i    (vb_q),
    .sensor_a_ok_i     (a_ok_q),
    .sensor_a_active_i (a_act_q),
    .sensor_b_ok_i     (b_ok_q),
    .sensor_b_active_i (b_act_q),
    .flags_o           (flags)
  );

  psis_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .command_i      (cmd_q),
    .request_bits_i (req_q),
    .flags_i        (flags),
    .status_o       (status)
  );

  // the state registers double as the status register
  assign out_valid_o          = out_valid_q;
  assign supply_mode_o        = status.mode;
  assign hard_interlocks_o    = status.hard_mask;
  assign soft_interlocks_o    = status.soft_mask;
  assign drive_enable_o       = status.drive_on;
  assign loop_open_o          = status.loop_open;
  assign controller_cleared_o = status.cleared;

  `PSIS_ASSERT_NOW(a_drive_only_when_on, drive_enable_o, supply_mode_o == MODE_ON,
    "drive enabled outside on mode")
  `PSIS_ASSERT_NOW(a_itlk_has_cause, supply_mode_o == MODE_ITLK,
    (hard_interlocks_o != '0) || (soft_interlocks_o != '0),
    "interlocked mode with no latched bit")
  `PSIS_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_q,
    "accepted beat not held in input stage")
  `PSIS_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_o,
    "processed beat not presented")

endmodule
